@@ design/rqpm_pkg.sv @@
// Shared types, constants and codes for the ROI QP offset map painter.
// No dependencies; every other design file imports this package.

package rqpm_pkg;

	localparam int MAX_MAP_COLUMNS = 64;
	localparam int MAX_MAP_ROWS    = 64;
	localparam int BLOCK_SIZE      = 64;
	localparam int BLOCK_SHIFT     = $clog2(BLOCK_SIZE);
	localparam int STORE_DEPTH     = MAX_MAP_COLUMNS * MAX_MAP_ROWS;
	localparam int ADDR_W          = $clog2(STORE_DEPTH);

	localparam int DIM_W      = 7;   // map columns/rows, 1..64
	localparam int AREA_W     = 13;  // columns * rows, up to 4096
	localparam int PIX_W      = 13;  // frame size in pixels
	localparam int QP_W       = 6;
	localparam int OFS_W      = 8;   // signed QP offset
	localparam int BOX_W      = 14;  // signed box coordinates
	localparam int BLK_W      = 8;   // box coordinate in blocks, signed
	localparam int EDGE_W     = 10;  // box far edge in blocks, signed
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 13;
	localparam int QDEPTH     = 2;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FRAME_WIDTH,
		REG_FRAME_HEIGHT,
		REG_ROI_QP,
		REG_BACKGROUND_QP,
		REG_BASE_QP
	} cfg_reg_t;

	typedef enum logic [1:0] {
		ACT_BEGIN,
		ACT_ADD,
		ACT_READ
	} act_t;

	// Work orders for the back end
	typedef enum logic [1:0] {
		BOP_NONE,
		BOP_FILL,
		BOP_PAINT,
		BOP_READ
	} bop_t;

	typedef enum logic [2:0] {
		BK_CLEAR,
		BK_IDLE,
		BK_FILL,
		BK_PAINT,
		BK_READ,
		BK_READ_DATA
	} bk_state_t;

	typedef struct packed {
		logic [PIX_W-1:0] frame_width;
		logic [PIX_W-1:0] frame_height;
		logic [QP_W-1:0]  roi_qp;
		logic [QP_W-1:0]  background_qp;
		logic [QP_W-1:0]  base_qp;
	} cfg_t;

	typedef struct packed {
		bop_t              op;
		logic [OFS_W-1:0]  value;
		logic [ADDR_W-1:0] index;
		logic [DIM_W-2:0]  x0;
		logic [DIM_W-1:0]  x1;
		logic [DIM_W-1:0]  y0;
		logic [DIM_W-1:0]  y1;
		logic [ADDR_W-1:0] row_base;
		logic [DIM_W-1:0]  cols;
		logic [DIM_W-1:0]  rows;
		logic              bad;
	} cmd_t;

	typedef struct packed {
		logic signed [OFS_W-1:0] qp_offset;
		logic [DIM_W-1:0]        map_columns;
		logic [DIM_W-1:0]        map_rows;
		logic                    index_bad;
	} res_t;

endpackage

@@ design/rqpm_front.sv @@
// Front end: takes items, converts boxes to block units, clips them and
// classifies each item into a back-end command. Depends on rqpm_pkg.

module rqpm_front (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           take,
	input  logic [1:0]                     action,
	input  logic signed [rqpm_pkg::BOX_W-1:0] box_left,
	input  logic signed [rqpm_pkg::BOX_W-1:0] box_top,
	input  logic signed [rqpm_pkg::BOX_W-1:0] box_wide,
	input  logic signed [rqpm_pkg::BOX_W-1:0] box_tall,
	input  logic [rqpm_pkg::ADDR_W-1:0]    entry_index,
	input  rqpm_pkg::cfg_t                 cfg,
	input  logic                           q_full,
	output logic                           push,
	output rqpm_pkg::cmd_t                 cmd,
	output logic                           front_busy
);
	import rqpm_pkg::*;

	function automatic logic [DIM_W-1:0] blocks_of(input logic [PIX_W-1:0] px,
		input int unsigned limit);
		logic [PIX_W:0] sum;
		logic [PIX_W:0] n;
		begin
			sum = {1'b0, px} + (PIX_W+1)'(BLOCK_SIZE - 1);
			n = sum >> BLOCK_SHIFT;
			if (n == '0) begin
				n = (PIX_W+1)'(1);
			end
			if (n > (PIX_W+1)'(limit)) begin
				n = (PIX_W+1)'(limit);
			end
			return n[DIM_W-1:0];
		end
	endfunction

	// Divide by the block size, truncating toward zero
	function automatic logic signed [BLK_W-1:0] to_blocks(input logic signed [BOX_W-1:0] v);
		logic signed [BOX_W-1:0] adj;
		begin
			adj = v + (v[BOX_W-1] ? $signed(BOX_W'(BLOCK_SIZE - 1)) : $signed(BOX_W'(0)));
			return BLK_W'(adj >>> BLOCK_SHIFT);
		end
	endfunction

	logic                      valid_s1;
	logic [1:0]                action_s1;
	logic signed [BOX_W-1:0]   left_s1, top_s1, wide_s1, tall_s1;
	logic [ADDR_W-1:0]         index_s1;

	logic                      valid_s2;
	logic [1:0]                action_s2;
	logic signed [BLK_W-1:0]   x_s2, y_s2;
	logic signed [EDGE_W-1:0]  xe_s2, ye_s2;
	logic [ADDR_W-1:0]         index_s2;
	logic [DIM_W-1:0]          cols_s2, rows_s2;
	logic [AREA_W-1:0]         area_s2;
	logic [OFS_W-1:0]          roi_val_s2, bg_val_s2;

	logic                      adv_s2, load_s2, load_s1;
	logic [DIM_W-1:0]          cols_n, rows_n;
	logic signed [BLK_W-1:0]   qx, qy, qw, qh;

	assign adv_s2  = valid_s2 && !q_full;
	assign load_s2 = !valid_s2 || adv_s2;
	assign load_s1 = !valid_s1 || load_s2;
	assign push    = adv_s2;
	assign front_busy = valid_s1 || valid_s2;

	assign cols_n = blocks_of(cfg.frame_width, MAX_MAP_COLUMNS);
	assign rows_n = blocks_of(cfg.frame_height, MAX_MAP_ROWS);
	assign qx = to_blocks(left_s1);
	assign qy = to_blocks(top_s1);
	assign qw = to_blocks(wide_s1);
	assign qh = to_blocks(tall_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (load_s1) begin
				valid_s1 <= take;
			end
			if (load_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1 && take) begin
			action_s1 <= action;
			left_s1   <= box_left;
			top_s1    <= box_top;
			wide_s1   <= box_wide;
			tall_s1   <= box_tall;
			index_s1  <= entry_index;
		end
		if (load_s2 && valid_s1) begin
			action_s2  <= action_s1;
			x_s2       <= qx;
			y_s2       <= qy;
			// far edge = position + size + 1, all in blocks
			xe_s2      <= EDGE_W'(qx) + EDGE_W'(qw) + EDGE_W'(1);
			ye_s2      <= EDGE_W'(qy) + EDGE_W'(qh) + EDGE_W'(1);
			index_s2   <= index_s1;
			cols_s2    <= cols_n;
			rows_s2    <= rows_n;
			area_s2    <= AREA_W'(cols_n * rows_n);
			roi_val_s2 <= OFS_W'(cfg.roi_qp) - OFS_W'(cfg.base_qp);
			bg_val_s2  <= OFS_W'(cfg.background_qp) - OFS_W'(cfg.base_qp);
		end
	end

	// Clip and classify
	logic signed [EDGE_W-1:0] cols_e, rows_e, xl, yl;
	logic [DIM_W-1:0]         x0w, y0w;
	logic                     paint, bad;

	always_comb begin
		cols_e = $signed({{(EDGE_W-DIM_W){1'b0}}, cols_s2});
		rows_e = $signed({{(EDGE_W-DIM_W){1'b0}}, rows_s2});
		x0w = x_s2[BLK_W-1] ? '0 : x_s2[DIM_W-1:0];
		y0w = y_s2[BLK_W-1] ? '0 : y_s2[DIM_W-1:0];
		xl = (xe_s2 > cols_e) ? cols_e : xe_s2;
		yl = (ye_s2 > rows_e) ? rows_e : ye_s2;
		paint = (xl > $signed({{(EDGE_W-DIM_W){1'b0}}, x0w}))
			&& (yl > $signed({{(EDGE_W-DIM_W){1'b0}}, y0w}));
		bad = {1'b0, index_s2} >= area_s2;

		cmd.op       = BOP_NONE;
		cmd.value    = '0;
		cmd.index    = index_s2;
		cmd.x0       = x0w[DIM_W-2:0];
		cmd.x1       = xl[DIM_W-1:0];
		cmd.y0       = y0w;
		cmd.y1       = yl[DIM_W-1:0];
		cmd.row_base = ADDR_W'(cols_s2 * y0w);
		cmd.cols     = cols_s2;
		cmd.rows     = rows_s2;
		cmd.bad      = 1'b0;
		unique case (action_s2)
			ACT_BEGIN: begin
				cmd.op    = BOP_FILL;
				cmd.value = bg_val_s2;
			end
			ACT_ADD: begin
				cmd.op    = paint ? BOP_PAINT : BOP_NONE;
				cmd.value = roi_val_s2;
			end
			ACT_READ: begin
				cmd.op  = bad ? BOP_NONE : BOP_READ;
				cmd.bad = bad;
			end
			default: begin
				cmd.op = BOP_NONE;
			end
		endcase
	end

endmodule

@@ design/rqpm_queue.sv @@
// Short command queue between the front end and the back end.
// Depends on rqpm_pkg for the command type and depth.

module rqpm_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  rqpm_pkg::cmd_t push_cmd,
	input  logic           pop,
	output rqpm_pkg::cmd_t head,
	output logic           empty,
	output logic           full
);
	import rqpm_pkg::*;

	localparam int PTR_W = $clog2(QDEPTH);
	localparam int CNT_W = $clog2(QDEPTH + 1);

	cmd_t             store_q [QDEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign empty = (count_q == '0);
	assign full  = (count_q == CNT_W'(QDEPTH));
	assign head  = store_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			store_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

@@ design/rqpm_back.sv @@
// Back end: owns the offset map memory, runs fill, paint and read commands
// and the clearing sweep after reset. Depends on rqpm_pkg.

module rqpm_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           q_empty,
	input  rqpm_pkg::cmd_t head,
	output logic           pop,
	output logic           back_busy,
	output logic           done,
	output rqpm_pkg::res_t res
);
	import rqpm_pkg::*;

	logic [OFS_W-1:0] store_q [STORE_DEPTH];
	logic [OFS_W-1:0] rdata_q;

	bk_state_t         state_q, state_d;
	cmd_t              cur_q, cur_d;
	logic [ADDR_W-1:0] cnt_q, cnt_d;
	logic [DIM_W-1:0]  col_q, col_d, row_q, row_d;
	logic [ADDR_W-1:0] base_q, base_d;
	logic              done_q, done_d;
	res_t              res_q, res_d;

	logic              mem_we;
	logic [ADDR_W-1:0] mem_waddr;
	logic [OFS_W-1:0]  mem_wdata;

	assign back_busy = (state_q != BK_IDLE);
	assign done = done_q;
	assign res  = res_q;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			store_q[mem_waddr] <= mem_wdata;
		end
		rdata_q <= store_q[cur_q.index];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_CLEAR;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			done_q  <= done_d;
		end
	end

	always_ff @(posedge clk) begin
		cur_q  <= cur_d;
		col_q  <= col_d;
		row_q  <= row_d;
		base_q <= base_d;
		if (done_d) begin
			res_q <= res_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		cur_d     = cur_q;
		cnt_d     = cnt_q;
		col_d     = col_q;
		row_d     = row_q;
		base_d    = base_q;
		pop       = 1'b0;
		mem_we    = 1'b0;
		mem_waddr = cnt_q;
		mem_wdata = '0;
		done_d    = 1'b0;
		res_d.qp_offset   = '0;
		res_d.map_columns = cur_q.cols;
		res_d.map_rows    = cur_q.rows;
		res_d.index_bad   = cur_q.bad;

		unique case (state_q)
			BK_CLEAR: begin
				mem_we = 1'b1;
				cnt_d  = cnt_q + ADDR_W'(1);
				if (cnt_q == ADDR_W'(STORE_DEPTH - 1)) begin
					state_d = BK_IDLE;
				end
			end
			BK_IDLE: begin
				if (!q_empty) begin
					pop    = 1'b1;
					cur_d  = head;
					cnt_d  = '0;
					col_d  = {1'b0, head.x0};
					row_d  = head.y0;
					base_d = head.row_base;
					unique case (head.op)
						BOP_FILL:  state_d = BK_FILL;
						BOP_PAINT: state_d = BK_PAINT;
						BOP_READ:  state_d = BK_READ;
						default: begin
							done_d = 1'b1;
							res_d.map_columns = head.cols;
							res_d.map_rows    = head.rows;
							res_d.index_bad   = head.bad;
						end
					endcase
				end
			end
			BK_FILL: begin
				mem_we    = 1'b1;
				mem_wdata = cur_q.value;
				cnt_d     = cnt_q + ADDR_W'(1);
				if (cnt_q == ADDR_W'(STORE_DEPTH - 1)) begin
					done_d  = 1'b1;
					state_d = BK_IDLE;
				end
			end
			BK_PAINT: begin
				mem_we    = 1'b1;
				mem_waddr = base_q + ADDR_W'(col_q);
				mem_wdata = cur_q.value;
				if (col_q + DIM_W'(1) == cur_q.x1) begin
					col_d  = {1'b0, cur_q.x0};
					row_d  = row_q + DIM_W'(1);
					base_d = base_q + ADDR_W'(cur_q.cols);
					if (row_q + DIM_W'(1) == cur_q.y1) begin
						done_d  = 1'b1;
						state_d = BK_IDLE;
					end
				end else begin
					col_d = col_q + DIM_W'(1);
				end
			end
			BK_READ: begin
				state_d = BK_READ_DATA;
			end
			BK_READ_DATA: begin
				done_d          = 1'b1;
				res_d.qp_offset = $signed(rdata_q);
				state_d         = BK_IDLE;
			end
			default: begin
				state_d = BK_IDLE;
			end
		endcase
	end

endmodule

@@ design/roi_qp_delta_map_painter_unit.sv @@
// Top level of the ROI QP offset map painter: register file, front end,
// command queue and back end. Depends on rqpm_pkg, rqpm_front, rqpm_queue, rqpm_back.
//
// Channel   | Ports                                                | Handshake
// ----------+------------------------------------------------------+----------------------
// command   | action, box_left, box_top, box_wide, box_tall,       | start high, busy low
//           | entry_index                                          |
// result    | qp_offset, map_columns, map_rows, index_bad          | done, one cycle
// config    | cfg_index, cfg_data                                  | cfg_we, no wait
//
// An add that paints nothing, an unused action or a bad read goes through the front end
// and the queue and gets done straight from the idle back end; a good read also waits
// for the memory read data, an add writes each painted block, and begin writes all 4096
// entries, one per cycle, through the single write port of the map memory.
// After reset the back end clears the map, one entry a cycle; busy
// stays high during the sweep. One item is in work at a time: busy is high from the
// edge after acceptance until the result strobe. The receiver cannot stall done.

module roi_qp_delta_map_painter_unit (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic [1:0]                          action,
	input  logic signed [rqpm_pkg::BOX_W-1:0]   box_left,
	input  logic signed [rqpm_pkg::BOX_W-1:0]   box_top,
	input  logic signed [rqpm_pkg::BOX_W-1:0]   box_wide,
	input  logic signed [rqpm_pkg::BOX_W-1:0]   box_tall,
	input  logic [rqpm_pkg::ADDR_W-1:0]         entry_index,
	output logic                                done,
	output logic signed [rqpm_pkg::OFS_W-1:0]   qp_offset,
	output logic [rqpm_pkg::DIM_W-1:0]          map_columns,
	output logic [rqpm_pkg::DIM_W-1:0]          map_rows,
	output logic                                index_bad,
	input  logic                                cfg_we,
	input  logic [rqpm_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [rqpm_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import rqpm_pkg::*;

	cfg_t cfg_q;
	logic take, push, pop, q_empty, q_full, front_busy, back_busy;
	cmd_t push_cmd, head;
	res_t res;

	// Take a new item only when nothing is in flight anywhere
	assign busy = front_busy || !q_empty || back_busy;
	assign take = start && !busy;

	// Configuration registers; writes to unused indexes drop
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.frame_width   <= PIX_W'(1920);
			cfg_q.frame_height  <= PIX_W'(1080);
			cfg_q.roi_qp        <= QP_W'(22);
			cfg_q.background_qp <= QP_W'(37);
			cfg_q.base_qp       <= QP_W'(32);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_FRAME_WIDTH:   cfg_q.frame_width   <= cfg_data[PIX_W-1:0];
				REG_FRAME_HEIGHT:  cfg_q.frame_height  <= cfg_data[PIX_W-1:0];
				REG_ROI_QP:        cfg_q.roi_qp        <= cfg_data[QP_W-1:0];
				REG_BACKGROUND_QP: cfg_q.background_qp <= cfg_data[QP_W-1:0];
				REG_BASE_QP:       cfg_q.base_qp       <= cfg_data[QP_W-1:0];
				default: ;
			endcase
		end
	end

	// Front end: convert, clip, classify
	rqpm_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.take       (take),
		.action     (action),
		.box_left   (box_left),
		.box_top    (box_top),
		.box_wide   (box_wide),
		.box_tall   (box_tall),
		.entry_index(entry_index),
		.cfg        (cfg_q),
		.q_full     (q_full),
		.push       (push),
		.cmd        (push_cmd),
		.front_busy (front_busy)
	);

	// Hold classified commands until the back end is free
	rqpm_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_cmd(push_cmd),
		.pop     (pop),
		.head    (head),
		.empty   (q_empty),
		.full    (q_full)
	);

	// Back end: walk the map memory and produce results
	rqpm_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_empty  (q_empty),
		.head     (head),
		.pop      (pop),
		.back_busy(back_busy),
		.done     (done),
		.res      (res)
	);

	assign qp_offset   = res.qp_offset;
	assign map_columns = res.map_columns;
	assign map_rows    = res.map_rows;
	assign index_bad   = res.index_bad;

endmodule

@@ design/rqpm_checker.sv @@
// Port-level checks for the ROI QP offset map painter, bound to the top level.
// Depends on rqpm_pkg and roi_qp_delta_map_painter_unit.

module rqpm_props (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              start,
	input logic                              busy,
	input logic                              done,
	input logic signed [rqpm_pkg::OFS_W-1:0] qp_offset,
	input logic [rqpm_pkg::DIM_W-1:0]        map_columns,
	input logic [rqpm_pkg::DIM_W-1:0]        map_rows,
	input logic                              index_bad
);
	import rqpm_pkg::*;

	// Busy is high right after an accepted item
	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("busy low right after an accepted item");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while work still in flight");

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("two results on back-to-back cycles");

	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && index_bad) |-> (qp_offset == '0))
		else $error("bad read returned a nonzero offset");

	a_map_size: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (map_columns != '0 && map_columns <= DIM_W'(MAX_MAP_COLUMNS)
			&& map_rows != '0 && map_rows <= DIM_W'(MAX_MAP_ROWS)))
		else $error("map size out of range");

endmodule

bind roi_qp_delta_map_painter_unit rqpm_props u_rqpm_props (
	.clk        (clk),
	.arst_n     (arst_n),
	.start      (start),
	.busy       (busy),
	.done       (done),
	.qp_offset  (qp_offset),
	.map_columns(map_columns),
	.map_rows   (map_rows),
	.index_bad  (index_bad)
);

@@ dv/rqpm_checker.sv @@
`timescale 1ns / 1ps
// Result checker for the ROI QP offset map painter: keeps its own copy of the
// offset map and the registers, predicts every result and compares it field by field.
// Depends on rqpm_pkg.

module rqpm_checker (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic                              busy,
	input  logic [1:0]                        action,
	input  logic signed [rqpm_pkg::BOX_W-1:0] box_left,
	input  logic signed [rqpm_pkg::BOX_W-1:0] box_top,
	input  logic signed [rqpm_pkg::BOX_W-1:0] box_wide,
	input  logic signed [rqpm_pkg::BOX_W-1:0] box_tall,
	input  logic [rqpm_pkg::ADDR_W-1:0]       entry_index,
	input  logic                              done,
	input  logic signed [rqpm_pkg::OFS_W-1:0] qp_offset,
	input  logic [rqpm_pkg::DIM_W-1:0]        map_columns,
	input  logic [rqpm_pkg::DIM_W-1:0]        map_rows,
	input  logic                              index_bad,
	input  logic                              cfg_we,
	input  logic [rqpm_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [rqpm_pkg::CFG_DATA_W-1:0]   cfg_data,
	output int                                fail_count,
	output int                                open_count
);

	import rqpm_pkg::*;

	logic [PIX_W-1:0] width_px;
	logic [PIX_W-1:0] height_px;
	logic [QP_W-1:0]  roi_q;
	logic [QP_W-1:0]  back_q;
	logic [QP_W-1:0]  base_q;
	logic [OFS_W-1:0] qp_map [STORE_DEPTH];
	res_t             awaited_results [$];
	res_t             oldest;
	int               fails;
	int               owed;

	assign fail_count = fails;
	assign open_count = owed;

	initial begin
		int i;
		width_px  = 13'd1920;
		height_px = 13'd1080;
		roi_q     = 6'd22;
		back_q    = 6'd37;
		base_q    = 6'd32;
		fails     = 0;
		owed      = 0;
		for (i = 0; i < STORE_DEPTH; i++)
			qp_map[i] = '0;
	end

	function automatic int blocks_across(int pixels, int limit);
		int n;
		n = (pixels + BLOCK_SIZE - 1) / BLOCK_SIZE;
		if (n < 1)
			n = 1;
		if (n > limit)
			n = limit;
		return n;
	endfunction

	// Apply one item to the map copy and return the result it owes.
	function automatic res_t paint_or_read(logic [1:0] act,
			logic signed [BOX_W-1:0] left_px, logic signed [BOX_W-1:0] top_px,
			logic signed [BOX_W-1:0] wide_px, logic signed [BOX_W-1:0] tall_px,
			logic [ADDR_W-1:0] idx);
		int               cols, rows, x, y, w, h, r, c;
		logic [OFS_W-1:0] ofs;
		res_t             res;
		cols            = blocks_across(int'(width_px), MAX_MAP_COLUMNS);
		rows            = blocks_across(int'(height_px), MAX_MAP_ROWS);
		res             = '0;
		res.map_columns = cols[DIM_W-1:0];
		res.map_rows    = rows[DIM_W-1:0];
		case (act)
			ACT_BEGIN: begin
				// the whole store is filled, not just the live map
				ofs = {2'b00, back_q} - {2'b00, base_q};
				for (r = 0; r < STORE_DEPTH; r++)
					qp_map[r] = ofs;
			end
			ACT_ADD: begin
				ofs = {2'b00, roi_q} - {2'b00, base_q};
				x   = int'(left_px) / BLOCK_SIZE;
				y   = int'(top_px) / BLOCK_SIZE;
				w   = int'(wide_px) / BLOCK_SIZE + 1;
				h   = int'(tall_px) / BLOCK_SIZE + 1;
				if (x < 0) begin
					w = w + x;
					x = 0;
				end
				if (y < 0) begin
					h = h + y;
					y = 0;
				end
				if (x + w > cols)
					w = cols - x;
				if (y + h > rows)
					h = rows - y;
				for (r = y; r < y + h; r++)
					for (c = x; c < x + w; c++)
						qp_map[(cols * r + c) % STORE_DEPTH] = ofs;
			end
			ACT_READ: begin
				if (int'(idx) >= cols * rows)
					res.index_bad = 1'b1;
				else
					res.qp_offset = qp_map[idx];
			end
			default: ;
		endcase
		return res;
	endfunction

	task automatic report_mismatch(string field, int got, int want);
		fails++;
		$display("[%0t] mismatch on %0s: got %0d, expected %0d", $time, field, got, want);
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (done) begin
				if (awaited_results.size() == 0) begin
					report_mismatch("result strobe with no item in flight", 1, 0);
				end else begin
					oldest = awaited_results.pop_front();
					if (qp_offset !== oldest.qp_offset)
						report_mismatch("qp_offset", int'(qp_offset), int'(oldest.qp_offset));
					if (map_columns !== oldest.map_columns)
						report_mismatch("map_columns", int'(map_columns),
							int'(oldest.map_columns));
					if (map_rows !== oldest.map_rows)
						report_mismatch("map_rows", int'(map_rows), int'(oldest.map_rows));
					if (index_bad !== oldest.index_bad)
						report_mismatch("index_bad", int'(index_bad), int'(oldest.index_bad));
				end
			end
			if (cfg_we) begin
				case (cfg_index)
					REG_FRAME_WIDTH:   width_px  = cfg_data[PIX_W-1:0];
					REG_FRAME_HEIGHT:  height_px = cfg_data[PIX_W-1:0];
					REG_ROI_QP:        roi_q     = cfg_data[QP_W-1:0];
					REG_BACKGROUND_QP: back_q    = cfg_data[QP_W-1:0];
					REG_BASE_QP:       base_q    = cfg_data[QP_W-1:0];
					default: ;
				endcase
			end
			if (start && !busy)
				awaited_results.insert(awaited_results.size(),
					paint_or_read(action, box_left, box_top,
					box_wide, box_tall, entry_index));
			owed <= awaited_results.size();
		end
	end

endmodule

@@ dv/tb.sv @@
`timescale 1ns / 1ps
// Top of the ROI QP offset map painter testbench: clock, reset, stimulus and verdict.
// Depends on rqpm_pkg, roi_qp_delta_map_painter_unit and rqpm_checker.

module tb;

	import rqpm_pkg::*;

	// Action code 3 has no enum member; the block must leave the map alone.
	localparam logic [1:0] ACT_UNUSED = 2'd3;
	// Worst case is every item painting or filling the full store, plus the
	// clearing sweep after reset; this is several times that.
	localparam int CYCLE_LIMIT = 3_000_000;

	logic                    clk;
	logic                    arst_n;
	logic                    start;
	logic                    busy;
	logic [1:0]              action;
	logic signed [BOX_W-1:0] box_left;
	logic signed [BOX_W-1:0] box_top;
	logic signed [BOX_W-1:0] box_wide;
	logic signed [BOX_W-1:0] box_tall;
	logic [ADDR_W-1:0]       entry_index;
	logic                    done;
	logic signed [OFS_W-1:0] qp_offset;
	logic [DIM_W-1:0]        map_columns;
	logic [DIM_W-1:0]        map_rows;
	logic                    index_bad;
	logic                    cfg_we;
	logic [CFG_IDX_W-1:0]    cfg_index;
	logic [CFG_DATA_W-1:0]   cfg_data;
	int                      fail_count;
	int                      open_count;

	// Stimulus shaping only: current frame size and map area, to aim boxes and reads.
	int cur_fw;
	int cur_fh;
	int cur_area;
	int items_by_action [4];
	int settings_loaded;
	int cycles;

	roi_qp_delta_map_painter_unit DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.action      (action),
		.box_left    (box_left),
		.box_top     (box_top),
		.box_wide    (box_wide),
		.box_tall    (box_tall),
		.entry_index (entry_index),
		.done        (done),
		.qp_offset   (qp_offset),
		.map_columns (map_columns),
		.map_rows    (map_rows),
		.index_bad   (index_bad),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	rqpm_checker u_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.action      (action),
		.box_left    (box_left),
		.box_top     (box_top),
		.box_wide    (box_wide),
		.box_tall    (box_tall),
		.entry_index (entry_index),
		.done        (done),
		.qp_offset   (qp_offset),
		.map_columns (map_columns),
		.map_rows    (map_rows),
		.index_bad   (index_bad),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.fail_count  (fail_count),
		.open_count  (open_count)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Watchdog: a hung handshake ends the run here.
	initial cycles = 0;
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("Watchdog expired after %0d cycles, %0d results outstanding",
				cycles, open_count);
			$display("TEST FAILED");
			$finish;
		end
	end

	// Present one item and hold it until the block takes it. Start is left high:
	// the caller either sends the next item straight away or idles.
	task automatic send_item(logic [1:0] act, int left_px, int top_px, int wide_px,
			int tall_px, int idx);
		action      <= act;
		box_left    <= left_px[BOX_W-1:0];
		box_top     <= top_px[BOX_W-1:0];
		box_wide    <= wide_px[BOX_W-1:0];
		box_tall    <= tall_px[BOX_W-1:0];
		entry_index <= idx[ADDR_W-1:0];
		start       <= 1'b1;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		items_by_action[act]++;
	endtask

	// Drop start and idle for the given gap; a gap of zero means back to back.
	task automatic idle_for(int n);
		if (n > 0) begin
			start <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	// Drop start and hold off until every item in flight has produced its result.
	// Every item yields exactly one result, so a short margin after that is enough.
	task automatic settle();
		start <= 1'b0;
		@(posedge clk);
		while (open_count != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(cfg_reg_t idx, int val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val[CFG_DATA_W-1:0];
		@(posedge clk);
	endtask

	// Reprogram all five registers with the block idle.
	task automatic load_setting(int fw, int fh, int roi, int bg, int base);
		int cols_hint, rows_hint;
		settle();
		write_reg(REG_FRAME_WIDTH, fw);
		write_reg(REG_FRAME_HEIGHT, fh);
		write_reg(REG_ROI_QP, roi);
		write_reg(REG_BACKGROUND_QP, bg);
		write_reg(REG_BASE_QP, base);
		cfg_we <= 1'b0;
		@(posedge clk);
		cols_hint = (fw + BLOCK_SIZE - 1) / BLOCK_SIZE;
		rows_hint = (fh + BLOCK_SIZE - 1) / BLOCK_SIZE;
		cols_hint = cols_hint < 1 ? 1 : (cols_hint > MAX_MAP_COLUMNS ? MAX_MAP_COLUMNS : cols_hint);
		rows_hint = rows_hint < 1 ? 1 : (rows_hint > MAX_MAP_ROWS ? MAX_MAP_ROWS : rows_hint);
		cur_fw   = fw;
		cur_fh   = fh;
		cur_area = cols_hint * rows_hint;
		settings_loaded++;
	endtask

	// One random item. Mostly boxes aimed at the frame and reads inside the map;
	// the rest are raw 14-bit boxes, out-of-range reads, fills and the unused code.
	task automatic random_item();
		int pick, l, t, wd, tl, idx;
		pick = $urandom_range(0, 99);
		l    = $urandom_range(0, 16383) - 8192;
		t    = $urandom_range(0, 16383) - 8192;
		wd   = $urandom_range(0, 16383) - 8192;
		tl   = $urandom_range(0, 16383) - 8192;
		idx  = $urandom_range(0, 4095);
		if (pick < 10) begin
			send_item(ACT_BEGIN, l, t, wd, tl, idx);
		end else if (pick < 50) begin
			// aim near the frame, straddling its left and top edges now and then
			l = $urandom_range(0, cur_fw + 192) - 160;
			t = $urandom_range(0, cur_fh + 192) - 160;
			if ($urandom_range(0, 4) == 0) begin
				wd = $urandom_range(0, cur_fw + 64) - 64;
				tl = $urandom_range(0, cur_fh + 64) - 64;
			end else begin
				wd = $urandom_range(0, 320) - 80;
				tl = $urandom_range(0, 320) - 80;
			end
			send_item(ACT_ADD, l, t, wd, tl, idx);
		end else if (pick < 58) begin
			send_item(ACT_ADD, l, t, wd, tl, idx);
		end else if (pick < 93) begin
			if ($urandom_range(0, 3) != 0)
				idx = $urandom_range(0, cur_area - 1);
			send_item(ACT_READ, l, t, wd, tl, idx);
		end else begin
			send_item(ACT_UNUSED, l, t, wd, tl, idx);
		end
	endtask

	// A well-formed frame: a fill, then random items, mostly boxes and reads. The sender works
	// in bursts with random gaps unless steady is set; hold_mid drains the block
	// halfway through.
	task automatic run_phase(int count, bit steady, bit hold_mid);
		int burst, k;
		send_item(ACT_BEGIN, $urandom_range(0, 16383), $urandom_range(0, 16383),
			$urandom_range(0, 16383), $urandom_range(0, 16383), $urandom_range(0, 4095));
		burst = $urandom_range(0, 6);
		for (k = 0; k < count; k++) begin
			random_item();
			if (hold_mid && k == count / 2) begin
				settle();
			end else if (!steady) begin
				if (burst > 0) begin
					burst--;
				end else begin
					idle_for($urandom_range(1, 14));
					burst = $urandom_range(0, 6);
				end
			end
		end
	endtask

	initial begin
		// Every input known from time zero, with reset held low at the start.
		arst_n          = 1'b0;
		start           = 1'b0;
		action          = ACT_BEGIN;
		box_left        = '0;
		box_top         = '0;
		box_wide        = '0;
		box_tall        = '0;
		entry_index     = '0;
		cfg_we          = 1'b0;
		cfg_index       = REG_FRAME_WIDTH;
		cfg_data        = '0;
		cur_fw          = 1920;
		cur_fh          = 1080;
		cur_area        = 510;
		settings_loaded = 1;
		items_by_action = '{0, 0, 0, 0};
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part on the reset setting: 1920x1080 gives a 30 x 17 map.
		// The block clears its map after reset (busy holds us off), so reads see zero.
		send_item(ACT_READ, 0, 0, 0, 0, 0);
		send_item(ACT_READ, 0, 0, 0, 0, 4095);                  // far beyond the map
		send_item(ACT_BEGIN, -1, -1, -1, -1, 4095);             // fill with +5
		idle_for($urandom_range(0, 3));
		send_item(ACT_READ, 0, 0, 0, 0, 509);                   // last live entry
		send_item(ACT_READ, 0, 0, 0, 0, 510);                   // first one past it
		send_item(ACT_ADD, 0, 0, 0, 0, 0);                      // single block at origin
		send_item(ACT_READ, 0, 0, 0, 0, 0);
		idle_for($urandom_range(0, 3));
		// most negative edge cancels the widest box: empty after clipping
		send_item(ACT_ADD, -8192, -8192, 8191, 8191, 0);
		// origin beyond the map on both axes: empty
		send_item(ACT_ADD, 8191, 8191, 8191, 8191, 0);
		// negative left and top clipped to zero
		send_item(ACT_ADD, -100, -70, 200, 130, 0);
		send_item(ACT_READ, 0, 0, 0, 0, 31);
		idle_for($urandom_range(0, 3));
		// width of one negative block and most negative height: nothing painted
		send_item(ACT_ADD, 100, 100, -64, -8192, 0);
		// small negative sizes truncate to zero, so still one block
		send_item(ACT_ADD, 130, 130, -63, -1, 0);
		// reaches past the right and bottom edges
		send_item(ACT_ADD, 1800, 1000, 500, 500, 0);
		send_item(ACT_READ, 0, 0, 0, 0, 509);
		send_item(ACT_UNUSED, 8191, -8192, 8191, -8192, 4095);
		idle_for($urandom_range(0, 3));
		send_item(ACT_ADD, 0, 0, 8191, 8191, 0);                // whole map
		send_item(ACT_READ, 0, 0, 0, 0, 255);
		send_item(ACT_BEGIN, 0, 0, 0, 0, 0);
		send_item(ACT_READ, 0, 0, 0, 0, 0);

		// Random frames over a range of settings, extremes first.
		load_setting(1, 1, 0, 51, 0);            // 1 x 1 map, largest positive offset
		run_phase(20, 1'b0, 1'b0);
		load_setting(4096, 4096, 51, 0, 51);     // full 64 x 64 map, no idling
		run_phase(20, 1'b1, 1'b0);
		load_setting(0, 0, 51, 0, 0);            // zero frame size still maps one block
		run_phase(20, 1'b0, 1'b0);
		load_setting(8191, 8191, 0, 0, 51);      // oversized frame saturates the map
		run_phase(20, 1'b0, 1'b0);
		load_setting(640, 65, 30, 40, 26);
		run_phase(20, 1'b0, 1'b1);
		load_setting($urandom_range(1, 4096), $urandom_range(1, 4096),
			$urandom_range(0, 51), $urandom_range(0, 51), $urandom_range(0, 51));
		run_phase(20, 1'b0, 1'b0);

		// Drain, then give a stray strobe time to show up.
		settle();
		repeat (16) @(posedge clk);

		$display("Sent %0d begin, %0d add, %0d read and %0d unused-code items",
			items_by_action[0], items_by_action[1], items_by_action[2], items_by_action[3]);
		$display("over %0d register settings; %0d mismatches reported",
			settings_loaded, fail_count);
		if (fail_count == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
